// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL module of the DHCP reply parser.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/dhcp_rp_pkg.sv =====
// Package of the DHCP reply parser: protocol constants, option codes,
// register indexes and the option walk phase type. Depends on nothing.
package dhcp_rp_pkg;

   // Default size of the byte window that is parsed per packet.
   localparam int MAX_BYTES_DEF = 1024;

   // Fixed header layout and filter values.
   localparam int OPT_START   = 240;
   localparam int MAC_FIRST   = 28;
   localparam int MAC_LEN     = 6;
   localparam int XID_FIRST   = 4;
   localparam int XID_LAST    = 7;
   localparam int OFFER_FIRST = 16;
   localparam int OFFER_LAST  = 19;
   localparam logic [15:0] SERVER_PORT = 16'd67;
   localparam logic [7:0]  BOOT_REPLY  = 8'd2;

   // Option codes.
   localparam logic [7:0] OPT_PAD       = 8'd0;
   localparam logic [7:0] OPT_MASK      = 8'd1;
   localparam logic [7:0] OPT_ROUTER    = 8'd3;
   localparam logic [7:0] OPT_LEASE     = 8'd51;
   localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
   localparam logic [7:0] OPT_SERVER_ID = 8'd54;
   localparam logic [7:0] OPT_END       = 8'd255;

   // Register indexes, selected by address bit 3.
   localparam logic REG_CLIENT_MAC = 1'b0;
   localparam logic REG_XID        = 1'b1;

   // Where the option walk stands within a code/length/value record.
   typedef enum logic [1:0] {
      PH_CODE,
      PH_LEN,
      PH_DATA
   } phase_type;

endpackage

// ===== rtl/dhcp_reply_parser_unit.sv =====
// DHCP reply parser: takes reply bytes, filters the packet and collects options.
// A result beat appears in the cycle after the beat carrying the last byte.
// One byte is taken per cycle; input stalls only while a result waits unread.
// The per-byte state update is a single pass of compares and captures.
// Synchronous active-high reset clears all state, held values, the result valid flag and the
// configuration registers, but not the result payload. Depends on dhcp_rp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dhcp_reply_parser_unit #(
   parameter int MAX_BYTES = dhcp_rp_pkg::MAX_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Byte input channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_source_addr,
   input  logic [15:0] req_source_port,
   input  logic        req_forget_server,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic [7:0]  rsp_message_type,
   output logic [31:0] rsp_assigned_ip,
   output logic [31:0] rsp_subnet_mask,
   output logic [31:0] rsp_gateway,
   output logic [31:0] rsp_lease_seconds,
   output logic [31:0] rsp_server_id,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CNT_W = $clog2(MAX_BYTES + 1);

   // Configuration registers.
   logic [47:0] client_mac_ff;
   logic [31:0] transaction_id_ff;

   // Per-packet state.
   logic [CNT_W-1:0]      byte_count_ff, byte_count_in;
   logic                  header_match_ff, header_match_in;
   logic                  filter_pass_ff, filter_pass_in;
   dhcp_rp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]            option_code_ff, option_code_in;
   logic [7:0]            option_left_ff, option_left_in;
   logic [7:0]            type_seen_ff, type_seen_in;
   logic                  end_seen_ff, end_seen_in;
   logic [2:0]            opt_pos_ff, opt_pos_in;
   logic [31:0]           offer_hold_ff, offer_hold_in;
   logic [31:0]           value_capture_ff, value_capture_in;

   // Held values that outlive a packet.
   logic [31:0] ip_ff, ip_in;
   logic [31:0] mask_ff, mask_in;
   logic [31:0] gateway_ff, gateway_in;
   logic [31:0] lease_ff, lease_in;
   logic [31:0] server_id_ff, server_id_in;
   logic [31:0] server_src_ff, server_src_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_accepted_ff, rsp_accepted_in;
   logic [7:0]  rsp_type_ff, rsp_type_in;
   logic [31:0] rsp_ip_ff, rsp_mask_ff, rsp_gateway_ff, rsp_lease_ff, rsp_server_id_ff;

   // Handshake and byte classification.
   logic             in_fire;
   logic             in_range;
   logic             walk_en;
   logic             csr_write;
   logic [CNT_W-1:0] idx;
   logic [2:0]       mac_k;
   logic [7:0]       mac_byte;
   logic [7:0]       xid_byte;
   logic [31:0]      sid_cur, ssrc_cur;
   logic             keep_server;
   logic [7:0]       code_eff;
   logic [31:0]      target_val;
   logic [31:0]      capture_new;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign in_fire    = req_valid && req_ready;
   assign idx        = byte_count_ff;
   assign in_range   = byte_count_ff < CNT_W'(MAX_BYTES);
   assign walk_en    = in_fire && in_range && (idx >= CNT_W'(dhcp_rp_pkg::OPT_START)) &&
                       header_match_ff && filter_pass_ff && !end_seen_ff;
   assign mac_k      = 3'(byte_count_ff - CNT_W'(dhcp_rp_pkg::MAC_FIRST));
   assign xid_byte   = 8'(transaction_id_ff >> {~idx[1:0], 3'b000});

   // Hardware address byte expected at the current header position.
   always_comb begin
      unique case (mac_k)
         3'd0:    mac_byte = client_mac_ff[47:40];
         3'd1:    mac_byte = client_mac_ff[39:32];
         3'd2:    mac_byte = client_mac_ff[31:24];
         3'd3:    mac_byte = client_mac_ff[23:16];
         3'd4:    mac_byte = client_mac_ff[15:8];
         3'd5:    mac_byte = client_mac_ff[7:0];
         default: mac_byte = 8'h00;
      endcase
   end

   // Remembered server as seen by this beat, after an optional forget.
   assign sid_cur  = (in_fire && req_forget_server) ? 32'd0 : server_id_ff;
   assign ssrc_cur = (in_fire && req_forget_server) ? 32'd0 : server_src_ff;

   // A server identifier option from the already remembered server is dropped.
   assign keep_server = (sid_cur != 32'd0) && (ssrc_cur == req_source_addr) &&
                        (sid_cur == req_source_addr);
   assign code_eff    = ((req_data_byte != 8'd0) || 1'b1) &&
                        (option_code_ff == dhcp_rp_pkg::OPT_SERVER_ID) && keep_server ?
                        dhcp_rp_pkg::OPT_PAD : option_code_ff;

   // Current value of the register that an option writes into.
   always_comb begin
      unique case (code_eff)
         dhcp_rp_pkg::OPT_MASK:      target_val = mask_ff;
         dhcp_rp_pkg::OPT_ROUTER:    target_val = gateway_ff;
         dhcp_rp_pkg::OPT_LEASE:     target_val = lease_ff;
         dhcp_rp_pkg::OPT_SERVER_ID: target_val = sid_cur;
         default:                    target_val = 32'd0;
      endcase
   end

   // Capture word with the current value byte placed at its position.
   always_comb begin
      capture_new = value_capture_ff;
      capture_new[{~opt_pos_ff[1:0], 3'b000} +: 8] = req_data_byte;
   end

   // Next phase of the option walk.
   always_comb begin
      phase_in = phase_ff;
      if (walk_en) begin
         unique case (phase_ff)
            dhcp_rp_pkg::PH_CODE: begin
               if (req_data_byte != dhcp_rp_pkg::OPT_PAD &&
                   req_data_byte != dhcp_rp_pkg::OPT_END) begin
                  phase_in = dhcp_rp_pkg::PH_LEN;
               end
            end
            dhcp_rp_pkg::PH_LEN: begin
               phase_in = (req_data_byte == 8'd0) ? dhcp_rp_pkg::PH_CODE :
                                                     dhcp_rp_pkg::PH_DATA;
            end
            dhcp_rp_pkg::PH_DATA: begin
               if (option_left_ff == 8'd1) begin
                  phase_in = dhcp_rp_pkg::PH_CODE;
               end
            end
            default: phase_in = dhcp_rp_pkg::PH_CODE;
         endcase
      end
      if (in_fire && req_last_byte) begin
         phase_in = dhcp_rp_pkg::PH_CODE;
      end
   end

   // Header checks, option captures and the result of the last byte.
   always_comb begin
      byte_count_in    = byte_count_ff;
      header_match_in  = header_match_ff;
      filter_pass_in   = filter_pass_ff;
      option_code_in   = option_code_ff;
      option_left_in   = option_left_ff;
      type_seen_in     = type_seen_ff;
      end_seen_in      = end_seen_ff;
      opt_pos_in       = opt_pos_ff;
      offer_hold_in    = offer_hold_ff;
      value_capture_in = value_capture_ff;
      ip_in            = ip_ff;
      mask_in          = mask_ff;
      gateway_in       = gateway_ff;
      lease_in         = lease_ff;
      server_id_in     = sid_cur;
      server_src_in    = ssrc_cur;
      rsp_accepted_in  = 1'b0;
      rsp_type_in      = 8'd0;

      if (in_fire && in_range) begin
         byte_count_in = byte_count_ff + CNT_W'(1);
         if (idx == CNT_W'(0)) begin
            // First byte: op code and source filter.
            header_match_in = (req_data_byte == dhcp_rp_pkg::BOOT_REPLY);
            filter_pass_in  = (req_source_port == dhcp_rp_pkg::SERVER_PORT) &&
                              ((sid_cur == 32'd0) || (req_source_addr == ssrc_cur) ||
                               (req_source_addr == sid_cur));
         end else if (idx >= CNT_W'(dhcp_rp_pkg::XID_FIRST) &&
                      idx <= CNT_W'(dhcp_rp_pkg::XID_LAST)) begin
            // Transaction id, most significant byte first.
            if (req_data_byte != xid_byte) begin
               header_match_in = 1'b0;
            end
         end else if (idx >= CNT_W'(dhcp_rp_pkg::OFFER_FIRST) &&
                      idx <= CNT_W'(dhcp_rp_pkg::OFFER_LAST)) begin
            // Offered address, held until the header is known good.
            offer_hold_in[{~idx[1:0], 3'b000} +: 8] = req_data_byte;
         end else if (idx >= CNT_W'(dhcp_rp_pkg::MAC_FIRST) &&
                      idx < CNT_W'(dhcp_rp_pkg::MAC_FIRST + dhcp_rp_pkg::MAC_LEN)) begin
            // Client hardware address; commit the offer after its last byte.
            if (req_data_byte != mac_byte) begin
               header_match_in = 1'b0;
            end
            if (mac_k == 3'(dhcp_rp_pkg::MAC_LEN - 1) && header_match_in && filter_pass_ff) begin
               ip_in = offer_hold_ff;
            end
         end else if (walk_en) begin
            unique case (phase_ff)
               dhcp_rp_pkg::PH_CODE: begin
                  if (req_data_byte == dhcp_rp_pkg::OPT_END) begin
                     end_seen_in = 1'b1;
                  end else if (req_data_byte != dhcp_rp_pkg::OPT_PAD) begin
                     option_code_in = req_data_byte;
                  end
               end
               dhcp_rp_pkg::PH_LEN: begin
                  option_left_in   = req_data_byte;
                  opt_pos_in       = 3'd0;
                  option_code_in   = code_eff;
                  value_capture_in = target_val;
                  if (option_code_ff == dhcp_rp_pkg::OPT_SERVER_ID && !keep_server) begin
                     server_src_in = req_source_addr;
                  end
               end
               dhcp_rp_pkg::PH_DATA: begin
                  // Only the first four value bytes are captured.
                  if (opt_pos_ff < 3'd4) begin
                     if (option_code_ff == dhcp_rp_pkg::OPT_MSG_TYPE && opt_pos_ff == 3'd0) begin
                        type_seen_in = req_data_byte;
                     end
                     unique case (option_code_ff)
                        dhcp_rp_pkg::OPT_MASK: begin
                           value_capture_in = capture_new;
                           mask_in          = capture_new;
                        end
                        dhcp_rp_pkg::OPT_ROUTER: begin
                           value_capture_in = capture_new;
                           gateway_in       = capture_new;
                        end
                        dhcp_rp_pkg::OPT_LEASE: begin
                           value_capture_in = capture_new;
                           lease_in         = capture_new;
                        end
                        dhcp_rp_pkg::OPT_SERVER_ID: begin
                           value_capture_in = capture_new;
                           server_id_in     = capture_new;
                        end
                        default: value_capture_in = value_capture_ff;
                     endcase
                     opt_pos_in = opt_pos_ff + 3'd1;
                  end
                  option_left_in = option_left_ff - 8'd1;
               end
               default: option_left_in = option_left_ff;
            endcase
         end
      end

      // Last byte: form the result, then return per-packet state to reset.
      if (in_fire && req_last_byte) begin
         rsp_accepted_in  = header_match_in && filter_pass_in &&
                            (byte_count_in >=
                             CNT_W'(dhcp_rp_pkg::MAC_FIRST + dhcp_rp_pkg::MAC_LEN));
         rsp_type_in      = (rsp_accepted_in && end_seen_in) ? type_seen_in : 8'd0;
         byte_count_in    = '0;
         header_match_in  = 1'b1;
         filter_pass_in   = 1'b0;
         option_code_in   = 8'd0;
         option_left_in   = 8'd0;
         type_seen_in     = 8'd0;
         end_seen_in      = 1'b0;
         opt_pos_in       = 3'd0;
         offer_hold_in    = 32'd0;
         value_capture_in = 32'd0;
      end
   end

   // Result beat is loaded on the last byte and held until taken.
   assign rsp_valid_in = (in_fire && req_last_byte) ? 1'b1 :
                         (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff    <= '0;
         header_match_ff  <= 1'b1;
         filter_pass_ff   <= 1'b0;
         phase_ff         <= dhcp_rp_pkg::PH_CODE;
         option_code_ff   <= 8'd0;
         option_left_ff   <= 8'd0;
         type_seen_ff     <= 8'd0;
         end_seen_ff      <= 1'b0;
         opt_pos_ff       <= 3'd0;
         offer_hold_ff    <= 32'd0;
         value_capture_ff <= 32'd0;
         ip_ff            <= 32'd0;
         mask_ff          <= 32'd0;
         gateway_ff       <= 32'd0;
         lease_ff         <= 32'd0;
         server_id_ff     <= 32'd0;
         server_src_ff    <= 32'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         byte_count_ff    <= byte_count_in;
         header_match_ff  <= header_match_in;
         filter_pass_ff   <= filter_pass_in;
         phase_ff         <= phase_in;
         option_code_ff   <= option_code_in;
         option_left_ff   <= option_left_in;
         type_seen_ff     <= type_seen_in;
         end_seen_ff      <= end_seen_in;
         opt_pos_ff       <= opt_pos_in;
         offer_hold_ff    <= offer_hold_in;
         value_capture_ff <= value_capture_in;
         ip_ff            <= ip_in;
         mask_ff          <= mask_in;
         gateway_ff       <= gateway_in;
         lease_ff         <= lease_in;
         server_id_ff     <= server_id_in;
         server_src_ff    <= server_src_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (in_fire && req_last_byte) begin
         rsp_accepted_ff  <= rsp_accepted_in;
         rsp_type_ff      <= rsp_type_in;
         rsp_ip_ff        <= ip_in;
         rsp_mask_ff      <= mask_in;
         rsp_gateway_ff   <= gateway_in;
         rsp_lease_ff     <= lease_in;
         rsp_server_id_ff <= server_id_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_message_type  = rsp_type_ff;
   assign rsp_assigned_ip   = rsp_ip_ff;
   assign rsp_subnet_mask   = rsp_mask_ff;
   assign rsp_gateway       = rsp_gateway_ff;
   assign rsp_lease_seconds = rsp_lease_ff;
   assign rsp_server_id     = rsp_server_id_ff;

   // Configuration registers; address bit 3 selects the register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         client_mac_ff     <= 48'd0;
         transaction_id_ff <= 32'd0;
      end else if (csr_write) begin
         unique case (csr_paddr[3])
            dhcp_rp_pkg::REG_CLIENT_MAC: client_mac_ff     <= csr_pwdata[47:0];
            dhcp_rp_pkg::REG_XID:        transaction_id_ff <= csr_pwdata[31:0];
            default:                     client_mac_ff     <= client_mac_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3])
         dhcp_rp_pkg::REG_CLIENT_MAC: csr_prdata = {16'd0, client_mac_ff};
         dhcp_rp_pkg::REG_XID:        csr_prdata = {32'd0, transaction_id_ff};
         default:                     csr_prdata = 64'd0;
      endcase
   end

   // A message type is reported only for an accepted packet.
   `ASSERT_ALWAYS(a_type_needs_accept, clock, reset, !rsp_valid_ff || rsp_type_ff == 8'd0 || rsp_accepted_ff, "message type on a rejected packet")
   // The last byte returns the byte counter and the option walk to their start.
   `ASSERT_NEXT(a_last_clears, clock, reset, in_fire && req_last_byte, byte_count_ff == '0 && phase_ff == dhcp_rp_pkg::PH_CODE && !end_seen_ff, "packet state not cleared after last byte")
   // The last byte always leaves a result beat behind.
   `ASSERT_NEXT(a_last_gives_rsp, clock, reset, in_fire && req_last_byte, rsp_valid_ff, "no result beat after last byte")
   // The value byte position never passes the four captured bytes.
   `ASSERT_ALWAYS(a_pos_bound, clock, reset, opt_pos_ff <= 3'd4, "option byte position out of range")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench of the DHCP reply parser: sends reply packets one byte beat at a
// time, predicts each per-packet result from the accepted beats and compares every field.
// Depends on dhcp_rp_pkg and dhcp_reply_parser_unit.
`timescale 1ns / 100ps

module tb_top;
   import dhcp_rp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BEATS   = 1500;
   localparam int RANDOM_REPLIES = 48;
   localparam int WINDOW         = MAX_BYTES_DEF;
   localparam logic [31:0] SRV_A = 32'hC0A8_0101;
   localparam logic [31:0] SRV_B = 32'h0A00_00FE;
   localparam logic [31:0] SRV_C = 32'hAC10_2001;

   // One result beat as the parser should present it.
   typedef struct {
      logic        accepted;
      logic [7:0]  msg_type;
      logic [31:0] ip;
      logic [31:0] mask;
      logic [31:0] gw;
      logic [31:0] lease;
      logic [31:0] srv_id;
   } reply_summary_t;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic [31:0] req_source_addr;
   logic [15:0] req_source_port;
   logic        req_forget_server;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_accepted;
   logic [7:0]  rsp_message_type;
   logic [31:0] rsp_assigned_ip;
   logic [31:0] rsp_subnet_mask;
   logic [31:0] rsp_gateway;
   logic [31:0] rsp_lease_seconds;
   logic [31:0] rsp_server_id;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   // Predicted parser state and its copy of the registers.
   logic [47:0] mac_cfg;
   logic [31:0] xid_cfg;
   int          pos_count;
   logic        hdr_ok;
   logic        src_ok;
   logic        end_flag;
   phase_type   walk_phase;
   logic [7:0]  cur_code;
   logic [7:0]  bytes_left;
   logic [7:0]  type_val;
   int          rec_pos;
   logic [31:0] offer_acc;
   logic [31:0] value_work;
   logic [31:0] held_ip;
   logic [31:0] held_mask;
   logic [31:0] held_gw;
   logic [31:0] held_lease;
   logic [31:0] held_srv_id;
   logic [31:0] held_srv_src;

   reply_summary_t pending_replies[$];
   logic [7:0]     reply_bytes[$];

   bit idling_on;
   int ready_hold = 0;
   int quiet_cycles;
   int packets_sent = 0;
   int parsed_beats = 0;
   int results_seen = 0;
   int accepted_seen = 0;
   int config_writes = 0;
   int fault_count = 0;

   dhcp_reply_parser_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .req_source_addr   (req_source_addr),
      .req_source_port   (req_source_port),
      .req_forget_server (req_forget_server),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_message_type  (rsp_message_type),
      .rsp_assigned_ip   (rsp_assigned_ip),
      .rsp_subnet_mask   (rsp_subnet_mask),
      .rsp_gateway       (rsp_gateway),
      .rsp_lease_seconds (rsp_lease_seconds),
      .rsp_server_id     (rsp_server_id),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] held_value(logic [7:0] code);
      case (code)
         OPT_MASK:      return held_mask;
         OPT_ROUTER:    return held_gw;
         OPT_LEASE:     return held_lease;
         OPT_SERVER_ID: return held_srv_id;
         default:       return 32'h0;
      endcase
   endfunction

   function automatic void store_held(logic [7:0] code, logic [31:0] v);
      case (code)
         OPT_MASK:      held_mask = v;
         OPT_ROUTER:    held_gw = v;
         OPT_LEASE:     held_lease = v;
         OPT_SERVER_ID: held_srv_id = v;
         default:       ;
      endcase
   endfunction

   function automatic void clear_walk_state();
      pos_count  = 0;
      hdr_ok     = 1'b1;
      src_ok     = 1'b0;
      walk_phase = PH_CODE;
      cur_code   = 8'h0;
      bytes_left = 8'h0;
      type_val   = 8'h0;
      end_flag   = 1'b0;
      rec_pos    = 0;
      offer_acc  = 32'h0;
      value_work = 32'h0;
   endfunction

   // One byte of the option area of an accepted packet.
   function automatic void walk_option(logic [7:0] b, logic [31:0] src);
      if (walk_phase == PH_CODE) begin
         if (b == OPT_END) begin
            end_flag = 1'b1;
         end else if (b != OPT_PAD) begin
            cur_code   = b;
            walk_phase = PH_LEN;
         end
      end else if (walk_phase == PH_LEN) begin
         bytes_left = b;
         rec_pos    = 0;
         // A server that repeats its own known identifier is left alone.
         if (cur_code == OPT_SERVER_ID) begin
            if (held_srv_id != 0 && held_srv_src == src && held_srv_id == src)
               cur_code = OPT_PAD;
            else
               held_srv_src = src;
         end
         value_work = held_value(cur_code);
         walk_phase = (b == 8'h0) ? PH_CODE : PH_DATA;
      end else begin
         // Only the first four value bytes land; the rest are skipped.
         if (rec_pos < 4) begin
            if (cur_code == OPT_MSG_TYPE && rec_pos == 0)
               type_val = b;
            if (cur_code inside {OPT_MASK, OPT_ROUTER, OPT_LEASE, OPT_SERVER_ID}) begin
               value_work[31 - 8 * rec_pos -: 8] = b;
               store_held(cur_code, value_work);
            end
            rec_pos++;
         end
         bytes_left = bytes_left - 8'd1;
         if (bytes_left == 8'h0)
            walk_phase = PH_CODE;
      end
   endfunction

   // One byte of the packet at index idx within the parsed window.
   function automatic void parse_byte(int idx, logic [7:0] b, logic [31:0] src,
                                      logic [15:0] port);
      int k;
      if (idx == 0) begin
         hdr_ok = (b == BOOT_REPLY);
         src_ok = (port == SERVER_PORT) &&
                  (held_srv_id == 0 || src == held_srv_src || src == held_srv_id);
      end else if (idx >= XID_FIRST && idx <= XID_LAST) begin
         if (xid_cfg[8 * (XID_LAST - idx) +: 8] != b)
            hdr_ok = 1'b0;
      end else if (idx >= OFFER_FIRST && idx <= OFFER_LAST) begin
         offer_acc[8 * (OFFER_LAST - idx) +: 8] = b;
      end else if (idx >= MAC_FIRST && idx < MAC_FIRST + MAC_LEN) begin
         k = idx - MAC_FIRST;
         if (mac_cfg[8 * (MAC_LEN - 1 - k) +: 8] != b)
            hdr_ok = 1'b0;
         // The offered address is committed once the whole header is known good.
         if (k == MAC_LEN - 1 && hdr_ok && src_ok)
            held_ip = offer_acc;
      end else if (idx >= OPT_START && hdr_ok && src_ok && !end_flag) begin
         walk_option(b, src);
      end
   endfunction

   // Applies one accepted input beat and queues the result it causes, if any.
   function automatic void parse_reply_beat(logic [7:0] b, logic last, logic [31:0] src,
                                            logic [15:0] port, logic forget);
      reply_summary_t r;
      if (forget) begin
         held_srv_id  = 32'h0;
         held_srv_src = 32'h0;
      end
      if (pos_count < WINDOW) begin
         parse_byte(pos_count, b, src, port);
         pos_count++;
         parsed_beats++;
      end
      if (last) begin
         r.accepted = hdr_ok && src_ok && pos_count >= MAC_FIRST + MAC_LEN;
         r.msg_type = (r.accepted && end_flag) ? type_val : 8'h0;
         r.ip       = held_ip;
         r.mask     = held_mask;
         r.gw       = held_gw;
         r.lease    = held_lease;
         r.srv_id   = held_srv_id;
         pending_replies.push_back(r);
         clear_walk_state();
      end
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
         fault_count++;
      end
   endfunction

   // Every result beat is compared with the oldest predicted one.
   always @(posedge clock) begin
      reply_summary_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: result beat with no packet pending, actual accepted %b type %h",
                     $time, rsp_accepted, rsp_message_type);
            fault_count++;
         end else begin
            want = pending_replies.pop_front();
            check_field("accepted", want.accepted, rsp_accepted);
            check_field("message_type", want.msg_type, rsp_message_type);
            check_field("assigned_ip", want.ip, rsp_assigned_ip);
            check_field("subnet_mask", want.mask, rsp_subnet_mask);
            check_field("gateway", want.gw, rsp_gateway);
            check_field("lease_seconds", want.lease, rsp_lease_seconds);
            check_field("server_id", want.srv_id, rsp_server_id);
            results_seen++;
            if (rsp_accepted)
               accepted_seen++;
         end
      end
   end

   // Result side back-pressure in random bursts.
   always @(negedge clock) begin
      if (ready_hold != 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(0, 7);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Ends the run when no beat or register access has moved for too long.
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
               WATCHDOG_LIMIT, pending_replies.size());
      $display("tb_top: errors");
      $finish;
   end

   // ---------------------------------------------------------------- driving

   // Sends one byte beat, with an occasional gap in front of it.
   task automatic send_beat(logic [7:0] b, logic last, logic [31:0] src, logic [15:0] port,
                            logic forget);
      int gap;
      if (idling_on && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_last_byte     <= last;
      req_source_addr   <= src;
      req_source_port   <= port;
      req_forget_server <= forget;
      do @(posedge clock); while (!req_ready);
      parse_reply_beat(b, last, src, port, forget);
   endtask

   // Sends the assembled packet; a noisy packet scrambles sender fields beat by beat.
   task automatic send_reply(logic [31:0] src, logic [15:0] port, logic forget_first,
                             logic noisy);
      logic        forget;
      logic [31:0] s;
      logic [15:0] p;
      for (int i = 0; i < reply_bytes.size(); i++) begin
         forget = (i == 0) ? forget_first : (noisy && $urandom_range(0, 31) == 0);
         s = (noisy && i > 0 && $urandom_range(0, 3) == 0) ? $urandom : src;
         p = (noisy && i > 0 && $urandom_range(0, 3) == 0) ? 16'($urandom) : port;
         send_beat(reply_bytes[i], i == reply_bytes.size() - 1, s, p, forget);
      end
      packets_sent++;
   endtask

   // Lets every pending result drain before the next register access.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write followed by a read back of the same register.
   task automatic write_reg(logic reg_sel, logic [63:0] value);
      logic [63:0] keep_bits;
      keep_bits = (reg_sel == REG_CLIENT_MAC) ? 64'hFFFF_FFFF_FFFF : 64'hFFFF_FFFF;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (reg_sel == REG_CLIENT_MAC)
         mac_cfg = value[47:0];
      else
         xid_cfg = value[31:0];
      config_writes++;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("register read", 32'((csr_prdata & keep_bits) != (value & keep_bits)),
                  32'h0);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_config(logic [47:0] mac, logic [31:0] xid);
      wait_idle();
      write_reg(REG_CLIENT_MAC, {16'h0, mac});
      write_reg(REG_XID, {32'h0, xid});
   endtask

   // ---------------------------------------------------------------- packet assembly

   function automatic void begin_reply(logic [7:0] op, logic [31:0] xid, logic [47:0] mac,
                                       logic [31:0] offer);
      logic [7:0] b;
      reply_bytes.delete();
      for (int i = 0; i < OPT_START; i++) begin
         b = 8'($urandom);
         if (i == 0)
            b = op;
         else if (i >= XID_FIRST && i <= XID_LAST)
            b = xid[8 * (XID_LAST - i) +: 8];
         else if (i >= OFFER_FIRST && i <= OFFER_LAST)
            b = offer[8 * (OFFER_LAST - i) +: 8];
         else if (i >= MAC_FIRST && i < MAC_FIRST + MAC_LEN)
            b = mac[8 * (MAC_FIRST + MAC_LEN - 1 - i) +: 8];
         reply_bytes.push_back(b);
      end
   endfunction

   // Value bytes past the fourth are random filler.
   function automatic void put_option(logic [7:0] code, int len, logic [31:0] val);
      reply_bytes.push_back(code);
      reply_bytes.push_back(8'(len));
      for (int k = 0; k < len; k++)
         reply_bytes.push_back(k < 4 ? val[31 - 8 * k -: 8] : 8'($urandom));
   endfunction

   // Well-formed reply for the current registers with a message type and an end option.
   function automatic void good_reply(logic [31:0] offer, logic [7:0] msg);
      begin_reply(BOOT_REPLY, xid_cfg, mac_cfg, offer);
      put_option(OPT_MSG_TYPE, 1, {msg, 24'h0});
      reply_bytes.push_back(OPT_END);
   endfunction

   function automatic void cut_reply(int keep);
      while (reply_bytes.size() > keep)
         void'(reply_bytes.pop_back());
   endfunction

   // A sender address that passes the server filter.
   function automatic logic [31:0] pick_source();
      if (held_srv_id != 0)
         return $urandom_range(0, 1) ? held_srv_id : held_srv_src;
      return $urandom;
   endfunction

   function automatic logic [47:0] pick_mac();
      case ($urandom_range(0, 3))
         0:       return 48'h0;
         1:       return 48'hFFFF_FFFF_FFFF;
         default: return {16'($urandom), 32'($urandom)};
      endcase
   endfunction

   function automatic logic [31:0] pick_xid();
      case ($urandom_range(0, 3))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   // Header, port and server filtering with the registers at their reset values.
   task automatic test_reply_filter();
      begin_reply(BOOT_REPLY, xid_cfg, mac_cfg, 32'hC0A8_0164);
      put_option(OPT_MSG_TYPE, 1, 32'h0200_0000);
      reply_bytes.push_back(OPT_PAD);
      put_option(OPT_MASK, 4, 32'hFFFF_FF00);
      put_option(OPT_ROUTER, 4, 32'hC0A8_0101);
      put_option(OPT_LEASE, 4, 32'h0001_5180);
      put_option(OPT_SERVER_ID, 4, SRV_A);
      put_option(8'd12, 3, 32'h6162_6300);
      reply_bytes.push_back(OPT_END);
      // Options after the end option must be ignored.
      put_option(OPT_MSG_TYPE, 1, 32'h0500_0000);
      put_option(OPT_MASK, 4, 32'h1234_5678);
      send_reply(SRV_A, SERVER_PORT, 1'b0, 1'b0);

      good_reply(32'h0A0A_0A0A, 8'd5);
      send_reply(SRV_A, SERVER_PORT + 16'd1, 1'b0, 1'b0);
      begin_reply(8'd1, xid_cfg, mac_cfg, 32'h0A0A_0A0B);
      reply_bytes.push_back(OPT_END);
      send_reply(SRV_A, SERVER_PORT, 1'b0, 1'b0);
      good_reply(32'h0A0A_0A0C, 8'd5);
      reply_bytes[XID_LAST] ^= 8'h01;
      send_reply(SRV_A, SERVER_PORT, 1'b0, 1'b0);
      good_reply(32'h0A0A_0A0D, 8'd5);
      reply_bytes[MAC_FIRST + MAC_LEN - 1] ^= 8'h80;
      send_reply(SRV_A, SERVER_PORT, 1'b0, 1'b0);

      // A foreign server is refused until the remembered one is forgotten.
      good_reply(32'h0A0A_0A0E, 8'd2);
      send_reply(SRV_B, SERVER_PORT, 1'b0, 1'b0);
      good_reply(32'h0A0A_0A0F, 8'd2);
      send_reply(SRV_B, SERVER_PORT, 1'b1, 1'b0);
   endtask

   // Packets that end before or inside the interesting parts.
   task automatic test_short_packets();
      reply_bytes.delete();
      reply_bytes.push_back(BOOT_REPLY);
      send_reply(SRV_B, SERVER_PORT, 1'b0, 1'b0);
      good_reply(32'h0B0B_0B01, 8'd5);
      cut_reply(MAC_FIRST + MAC_LEN - 1);
      send_reply(SRV_B, SERVER_PORT, 1'b0, 1'b0);
      good_reply(32'h0B0B_0B02, 8'd5);
      cut_reply(MAC_FIRST + MAC_LEN);
      send_reply(SRV_B, SERVER_PORT, 1'b0, 1'b0);
      // Accepted, but without an end option the type reads as zero.
      begin_reply(BOOT_REPLY, xid_cfg, mac_cfg, 32'h0B0B_0B03);
      put_option(OPT_MSG_TYPE, 1, 32'h0600_0000);
      put_option(OPT_MASK, 4, 32'hFFFF_0000);
      send_reply(SRV_B, SERVER_PORT, 1'b0, 1'b0);
      // Packet ends after two value bytes of the router option.
      begin_reply(BOOT_REPLY, xid_cfg, mac_cfg, 32'h0B0B_0B04);
      put_option(OPT_ROUTER, 4, 32'hAABB_CCDD);
      cut_reply(reply_bytes.size() - 2);
      send_reply(SRV_B, SERVER_PORT, 1'b0, 1'b0);
   endtask

   // Short, long and empty options, pads, and a server repeating its identifier.
   task automatic test_option_corners();
      begin_reply(BOOT_REPLY, xid_cfg, mac_cfg, 32'h0C0C_0C01);
      put_option(OPT_MASK, 2, 32'hAABB_CCDD);
      put_option(OPT_LEASE, 6, 32'h1234_5678);
      put_option(OPT_MSG_TYPE, 1, 32'h0300_0000);
      put_option(OPT_MSG_TYPE, 0, 32'h0);
      put_option(OPT_SERVER_ID, 0, 32'h0);
      reply_bytes.push_back(OPT_PAD);
      reply_bytes.push_back(OPT_PAD);
      put_option(OPT_ROUTER, 1, 32'hFF00_0000);
      put_option(8'd200, 0, 32'h0);
      reply_bytes.push_back(OPT_END);
      send_reply(SRV_C, SERVER_PORT, 1'b1, 1'b0);

      // The server names itself, then repeats with another identifier that is dropped.
      begin_reply(BOOT_REPLY, xid_cfg, mac_cfg, 32'h0C0C_0C02);
      put_option(OPT_SERVER_ID, 4, SRV_A);
      put_option(OPT_MSG_TYPE, 2, 32'hFFFF_0000);
      reply_bytes.push_back(OPT_END);
      send_reply(SRV_A, SERVER_PORT, 1'b1, 1'b0);
      begin_reply(BOOT_REPLY, xid_cfg, mac_cfg, 32'h0C0C_0C03);
      put_option(OPT_SERVER_ID, 4, SRV_B);
      put_option(OPT_MASK, 4, 32'hFFFF_FFFF);
      put_option(OPT_MSG_TYPE, 1, 32'h0500_0000);
      reply_bytes.push_back(OPT_END);
      send_reply(SRV_A, SERVER_PORT, 1'b0, 1'b0);
   endtask

   // All-ones registers and the extremes of the sender fields.
   task automatic test_field_extremes();
      set_config(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      begin_reply(BOOT_REPLY, xid_cfg, mac_cfg, 32'hFFFF_FFFF);
      put_option(OPT_LEASE, 4, 32'hFFFF_FFFF);
      put_option(OPT_SERVER_ID, 4, 32'hFFFF_FFFF);
      put_option(OPT_MSG_TYPE, 1, 32'hFF00_0000);
      reply_bytes.push_back(OPT_END);
      send_reply(32'hFFFF_FFFF, SERVER_PORT, 1'b1, 1'b0);
      good_reply(32'h0, 8'd5);
      send_reply(32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0);
      good_reply(32'h0, 8'd5);
      send_reply(32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b0);
      good_reply(32'h0, 8'd5);
      send_reply(32'h0, SERVER_PORT, 1'b0, 1'b0);
      good_reply(32'h0, 8'd0);
      send_reply(32'h0, SERVER_PORT, 1'b1, 1'b0);
      set_config(48'h0200_5E10_2030, 32'h3903_F326);
   endtask

   // A packet longer than the window: only its first bytes count.
   task automatic test_long_packet();
      begin_reply(BOOT_REPLY, xid_cfg, mac_cfg, 32'h0D0D_0D01);
      put_option(OPT_MSG_TYPE, 1, 32'h0200_0000);
      while (reply_bytes.size() < WINDOW - 4)
         reply_bytes.push_back(OPT_PAD);
      put_option(OPT_MASK, 4, 32'h1122_3344);
      reply_bytes.push_back(OPT_END);
      repeat (70) reply_bytes.push_back(8'($urandom));
      send_reply(SRV_A, SERVER_PORT, 1'b1, 1'b0);
   endtask

   // One random packet: mostly well-formed replies, some broken ones and some noise.
   task automatic random_reply();
      int          pick;
      int          len;
      logic [7:0]  code;
      logic [31:0] src;
      logic [31:0] val;
      logic [15:0] port;
      logic        forget;
      pick   = $urandom_range(0, 99);
      forget = ($urandom_range(0, 15) == 0);
      src    = forget ? $urandom : pick_source();
      port   = SERVER_PORT;
      if (pick < 12) begin
         reply_bytes.delete();
         repeat ($urandom_range(1, 300)) reply_bytes.push_back(8'($urandom));
         if ($urandom_range(0, 1))
            reply_bytes[0] = BOOT_REPLY;
         port = $urandom_range(0, 1) ? SERVER_PORT : 16'($urandom);
         send_reply($urandom, port, forget, 1'b1);
      end else begin
         begin_reply(BOOT_REPLY, xid_cfg, mac_cfg, $urandom);
         repeat ($urandom_range(0, 8)) begin
            val = $urandom;
            case ($urandom_range(0, 7))
               0: code = OPT_MSG_TYPE;
               1: code = OPT_MASK;
               2: code = OPT_ROUTER;
               3: code = OPT_LEASE;
               4: code = OPT_SERVER_ID;
               5: code = OPT_PAD;
               default: code = 8'($urandom_range(1, 254));
            endcase
            len = (code == OPT_MSG_TYPE) ? 1 : 4;
            if (code == OPT_MSG_TYPE)
               val[31:24] = 8'($urandom_range(1, 8));
            if (code == OPT_SERVER_ID && $urandom_range(0, 1))
               val = src;
            if ($urandom_range(0, 3) == 0)
               len = $urandom_range(0, 10);
            if (code == OPT_PAD)
               reply_bytes.push_back(OPT_PAD);
            else
               put_option(code, len, val);
         end
         if ($urandom_range(0, 7) != 0)
            reply_bytes.push_back(OPT_END);
         repeat ($urandom_range(0, 6)) reply_bytes.push_back(8'($urandom));
         if ($urandom_range(0, 9) == 0)
            cut_reply($urandom_range(1, reply_bytes.size()));
         if (pick == 99)
            repeat ($urandom_range(WINDOW - reply_bytes.size(), WINDOW + 60 -
                    reply_bytes.size())) reply_bytes.push_back(8'($urandom));
         // Broken replies: one header field or sender field is wrong.
         if (pick < 30) begin
            case ($urandom_range(0, 4))
               0: reply_bytes[0] ^= 8'($urandom_range(1, 255));
               1: reply_bytes[$urandom_range(XID_FIRST, XID_LAST)] ^= 8'($urandom_range(1, 255));
               2: reply_bytes[$urandom_range(MAC_FIRST, MAC_FIRST + MAC_LEN - 1)] ^=
                     8'($urandom_range(1, 255));
               3: port = 16'($urandom);
               default: src = $urandom;
            endcase
         end
         send_reply(src, port, forget, 1'b0);
      end
   endtask

   // Random traffic in several register settings, ending with a stretch without idling.
   task automatic test_random_traffic();
      int start_beats;
      int start_results;
      int n;
      start_beats   = parsed_beats;
      start_results = results_seen;
      n = 0;
      while (parsed_beats - start_beats < RANDOM_BEATS ||
             results_seen - start_results < RANDOM_REPLIES) begin
         if (n % 12 == 11)
            set_config(pick_mac(), pick_xid());
         idling_on = ($urandom_range(0, 3) != 0);
         random_reply();
         n++;
      end
      idling_on = 1'b0;
      repeat (8) random_reply();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data_byte     = 8'h0;
      req_last_byte     = 1'b0;
      req_source_addr   = 32'h0;
      req_source_port   = 16'h0;
      req_forget_server = 1'b0;
      rsp_ready         = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = 4'h0;
      csr_pwdata        = 64'h0;
      idling_on         = 1'b1;
      mac_cfg           = 48'h0;
      xid_cfg           = 32'h0;
      held_ip           = 32'h0;
      held_mask         = 32'h0;
      held_gw           = 32'h0;
      held_lease        = 32'h0;
      held_srv_id       = 32'h0;
      held_srv_src      = 32'h0;
      clear_walk_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reply_filter();
      test_short_packets();
      test_option_corners();
      test_field_extremes();
      test_long_packet();
      test_random_traffic();
      wait_idle();
      repeat (8) @(posedge clock);

      $display("Sent %0d packets with %0d parsed byte beats; %0d results checked, %0d accepted.",
               packets_sent, parsed_beats, results_seen, accepted_seen);
      $display("Covered header and server filtering, short and long packets, option corners"
               + " and %0d register writes.", config_writes);
      if (fault_count == 0 && pending_replies.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
